/* sv/sbh_pkg.sv */
// Shared types, constants and round functions of the SHA-256 block hasher.
package sbh_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_RUN,
    ST_ADD,
    ST_OUT
  } sbh_state_e;

  localparam int unsigned WordW    = 32;
  localparam int unsigned BlockLen = 16;
  localparam int unsigned Rounds   = 64;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

/* sv/sha256_block_hasher_unit.sv */
// SHA-256 hasher over a padded message, one 32-bit word per input beat.
//
// Input channel: message_word_i with last_word_i, accepted when in_valid_i is
// high and in_stall_o is low. Words are big-endian, first byte in bits 31..24.
// Output channel: eight digest beats after each last word, index 0 first,
// digest_last_o set on index 7; a beat moves when out_valid_o is high and
// out_stall_i is low.
// Words go straight into a 16-entry block memory, one per cycle, while the
// block is idle. On the sixteenth word or a last word the unit compresses:
// a prime state starts the memory reads, a run state computes the schedule
// and one round per cycle (the schedule runs one word ahead of the round and
// is written back in place), and an add state adds into the chaining value.
// After a last word the eight digest beats follow, one per cycle when not
// stalled, and the chaining value returns to its initial value.
// The input stalls during compression and digest output.
// Reset loads the initial hash words and empties the block.
module sha256_block_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  digest_index_o,
  output logic        digest_last_o
);
  import sbh_pkg::*;

  sbh_state_e  state_q, state_d;
  logic [6:0]  cnt_q;
  logic [3:0]  wc_q;
  logic [4:0]  n_q;
  logic        last_q;
  logic [2:0]  oidx_q;
  logic [31:0] chain_q [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] w1_q, w2_q, w16_q;
  logic [31:0] rda_q, rdb_q;
  logic [31:0] mem_q [BlockLen];

  logic        in_acc, out_acc, blk_end;
  logic        sched_act, round_act;
  logic [6:0]  nc;
  logic [3:0]  addr_a, addr_b;
  logic        mem_we;
  logic [3:0]  mem_wa;
  logic [31:0] mem_wd;
  logic [31:0] w_new;
  logic [31:0] t1, t2;
  logic [5:0]  rnd;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_acc   = out_valid_o && !out_stall_i;
  assign blk_end   = (wc_q == 4'd15) || last_word_i;
  assign sched_act = (state_q == ST_RUN) && (cnt_q < 7'(Rounds));
  assign round_act = (state_q == ST_RUN) && (cnt_q != 7'd0);
  assign rnd       = 6'(cnt_q - 7'd1);

  // Read addresses for the schedule word of the next cycle.
  assign nc     = (state_q == ST_PRIME) ? 7'd0 : 7'(cnt_q + 7'd1);
  assign addr_a = (nc < 7'(BlockLen)) ? nc[3:0] : 4'(nc[3:0] - 4'd7);
  assign addr_b = 4'(nc[3:0] + 4'd1);

  // Message words past the last one of a short block count as zero.
  always_comb begin
    if (cnt_q < 7'(BlockLen)) begin
      w_new = (cnt_q < 7'(n_q)) ? rda_q : '0;
    end else begin
      w_new = ssig1(w2_q) + rda_q + ssig0(rdb_q) + w16_q;
    end
  end

  assign mem_we = in_acc || sched_act;
  assign mem_wa = in_acc ? wc_q : cnt_q[3:0];
  assign mem_wd = in_acc ? message_word_i : w_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rda_q <= mem_q[addr_a];
    rdb_q <= mem_q[addr_b];
  end

  always_comb begin
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + K_TABLE[rnd] + w1_q;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    v_d[0] = t1 + t2;
    v_d[1] = v_q[0];
    v_d[2] = v_q[1];
    v_d[3] = v_q[2];
    v_d[4] = v_q[3] + t1;
    v_d[5] = v_q[4];
    v_d[6] = v_q[5];
    v_d[7] = v_q[6];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PRIME) begin
      v_q <= chain_q;
    end else if (round_act) begin
      v_q <= v_d;
    end
    if (sched_act) begin
      w1_q <= w_new;
      w2_q <= w1_q;
    end
    if (state_q == ST_RUN) begin
      w16_q <= rdb_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && blk_end) begin
          state_d = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_q == 7'(Rounds)) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        state_d = last_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_acc && (oidx_q == 3'd7)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      wc_q    <= '0;
      n_q     <= '0;
      last_q  <= 1'b0;
      oidx_q  <= '0;
      chain_q <= H_INIT;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        wc_q <= blk_end ? 4'd0 : 4'(wc_q + 4'd1);
        if (blk_end) begin
          n_q    <= 5'({1'b0, wc_q} + 5'd1);
          last_q <= last_word_i;
        end
      end
      if (state_q == ST_PRIME) begin
        cnt_q <= '0;
      end else if (state_q == ST_RUN) begin
        cnt_q <= 7'(cnt_q + 7'd1);
      end
      if (state_q == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
        oidx_q <= '0;
      end
      if (out_acc) begin
        oidx_q <= 3'(oidx_q + 3'd1);
        if (oidx_q == 3'd7) begin
          chain_q <= H_INIT;
          last_q  <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o    = (state_q == ST_OUT);
  assign digest_word_o  = chain_q[oidx_q];
  assign digest_index_o = oidx_q;
  assign digest_last_o  = (oidx_q == 3'd7);

`ifndef ASSERT_OFF
  // Input and output never move in the same phase.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input open while digest beats are pending");

  // The final digest beat ends the output phase.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && digest_last_o |=> !out_valid_o && !in_stall_o)
    else $error("output phase did not end after the last digest beat");

  // The round counter never runs past the final round.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> cnt_q <= 7'(Rounds))
    else $error("round counter out of range");

  // No pending digest once the block is idle again.
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !last_q)
    else $error("pending last flag while idle");

  // A short block never reports more words than a block holds.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> (n_q != 5'd0) && (n_q <= 5'(BlockLen)))
    else $error("block fill count out of range");
`endif

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the SHA-256 block hasher unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned DrainCycles   = 100;
  localparam int unsigned StallLimit    = 5000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomWords   = 70;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] message_word_i = '0;
  logic        last_word_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  digest_index_o;
  logic        digest_last_o;

  // Predicted hasher state.
  logic [31:0]  sha_chain [8];
  logic [31:0]  sha_block [16];
  int unsigned  sha_pos;
  digest_beat_t pending_digest_q [$];

  bit           idle_en = 1'b1;
  int unsigned  hold_len = 0;
  int unsigned  err_cnt = 0;
  int unsigned  quiet_cycles = 0;
  digest_beat_t want;

  sha256_block_hasher_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .message_word_i(message_word_i),
    .last_word_i   (last_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .digest_word_o (digest_word_o),
    .digest_index_o(digest_index_o),
    .digest_last_o (digest_last_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic void compress_into_chain();
    logic [31:0] sched [64];
    logic [31:0] wv [8];
    logic [31:0] x, y, ch, maj, t1, t2;
    for (int i = 0; i < 16; i++) sched[i] = sha_block[i];
    for (int i = 16; i < 64; i++) begin
      x = sched[i-15];
      y = sched[i-2];
      sched[i] = (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10)) + sched[i-7]
               + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + sched[i-16];
    end
    for (int i = 0; i < 8; i++) wv[i] = sha_chain[i];
    for (int i = 0; i < 64; i++) begin
      ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
      maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
      t1  = wv[7] + (ror32(wv[4], 6) ^ ror32(wv[4], 11) ^ ror32(wv[4], 25)) + ch
          + ROUND_K[i] + sched[i];
      t2  = (ror32(wv[0], 2) ^ ror32(wv[0], 13) ^ ror32(wv[0], 22)) + maj;
      for (int j = 7; j > 0; j--) wv[j] = wv[j-1];
      wv[4] = wv[4] + t1;
      wv[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) sha_chain[i] += wv[i];
  endfunction

  // Updates the predicted state with one accepted word and queues the digest after a last word.
  function automatic void absorb_word(input logic [31:0] word, input logic last);
    digest_beat_t beat;
    sha_block[sha_pos] = word;
    if (sha_pos == 15 || last) begin
      for (int i = sha_pos + 1; i < 16; i++) sha_block[i] = '0;
      compress_into_chain();
      sha_pos = 0;
    end else begin
      sha_pos++;
    end
    if (last) begin
      for (int i = 0; i < 8; i++) begin
        beat.word = sha_chain[i];
        beat.idx  = 3'(i);
        beat.fin  = (i == 7);
        pending_digest_q.push_back(beat);
        sha_chain[i] = INIT_H[i];
      end
    end
  endfunction

  function automatic void flag_error(input string msg);
    if (err_cnt < 10) $display("%s", msg);
    err_cnt++;
  endfunction

  // Offers one word; valid stays high afterwards so back-to-back beats need no gap.
  task automatic send_word(input logic [31:0] word, input logic last);
    if (idle_en && $urandom_range(99) < 6) begin
      @(negedge clk_i);
      in_valid_i     <= 1'b0;
      message_word_i <= $urandom();
      last_word_i    <= 1'($urandom_range(1));
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    message_word_i <= word;
    last_word_i    <= last;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    absorb_word(word, last);
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_word($urandom(), i == len - 1);
  endtask

  task automatic wait_for_digests();
    release_input();
    while (pending_digest_q.size() != 0) @(posedge clk_i);
  endtask

  // Last flag in the middle of a block, with all-ones and all-zero words.
  task automatic test_short_messages();
    send_word(32'hffffffff, 1'b1);
    send_word(32'h00000000, 1'b0);
    send_word(32'h80000000, 1'b1);
    send_word(32'h00000000, 1'b1);
  endtask

  // The padded message "abc": the last flag lands on the sixteenth word.
  task automatic test_abc_vector();
    send_word(32'h61626380, 1'b0);
    for (int i = 1; i < 15; i++) send_word(32'h00000000, 1'b0);
    send_word(32'h00000018, 1'b1);
  endtask

  // The receiver holds off long enough for the unit to back up into its input.
  task automatic test_receiver_holdoff();
    hold_len = HoldOffCycles;
    for (int i = 0; i < 3; i++) send_message($urandom_range(1, 3));
  endtask

  task automatic test_sender_pause();
    send_message($urandom_range(1, 20));
    wait_for_digests();
    send_message($urandom_range(1, 20));
  endtask

  task automatic test_random_messages();
    int unsigned words_sent;
    int unsigned msgs;
    int unsigned len;
    words_sent = 0;
    msgs = 0;
    while (words_sent < RandomWords) begin
      case ($urandom_range(9))
        0, 1:    len = 16 * $urandom_range(1, 2);
        2, 3:    len = $urandom_range(17, 40);
        default: len = $urandom_range(1, 15);
      endcase
      // A stretch of messages with neither side idling.
      if (msgs == 3) idle_en = 1'b0;
      if (msgs == 7) idle_en = 1'b1;
      send_message(len);
      words_sent += len;
      msgs++;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_len > 0) begin
      out_stall_i <= 1'b1;
      hold_len = hold_len - 1;
    end else begin
      out_stall_i <= idle_en && ($urandom_range(99) < 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_digest_q.size() == 0) begin
        flag_error($sformatf("unexpected digest beat: word %h index %0d last %0b",
                             digest_word_o, digest_index_o, digest_last_o));
      end else begin
        want = pending_digest_q.pop_front();
        if (digest_word_o !== want.word || digest_index_o !== want.idx ||
            digest_last_o !== want.fin) begin
          flag_error($sformatf({"digest beat mismatch: expected word %h index %0d ",
                                "last %0b, got word %h index %0d last %0b"},
                               want.word, want.idx, want.fin,
                               digest_word_o, digest_index_o, digest_last_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 8; i++) sha_chain[i] = INIT_H[i];
    for (int i = 0; i < 16; i++) sha_block[i] = '0;
    sha_pos = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_short_messages();
    test_abc_vector();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_messages();

    wait_for_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_digest_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
